// ===== src/lrpt_pkg.sv =====
package lrpt_pkg;

    localparam int TAB_W    = 8;
    localparam int TUP_W    = 31;
    // (table*10 + tuple mod 10) stays below 2570
    localparam int HASH_W   = 12;
    // compare-subtract steps of the slot reduction done per cycle
    localparam int RED_PER  = 4;
    localparam int RED_CYC  = HASH_W / RED_PER;
    // floor(x*RECIP >> 16) == floor(x/10) for every x below 4096
    localparam logic [12:0] RECIP = 13'd6554;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_HELD     = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [TUP_W-1:0] tup;
        logic [TAB_W-1:0] tab;
    } t_entry;

    typedef struct packed {
        logic [TAB_W-1:0] tab;
        logic [TUP_W-1:0] tup;
    } t_key;

endpackage

// ===== src/lrpt_req_if.sv =====
interface lrpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  table_num;
    logic [30:0] tuple_num;
    logic        lock_mode;

    modport source (output valid, req_type, table_num, tuple_num, lock_mode, input ready);
    modport sink   (input valid, req_type, table_num, tuple_num, lock_mode, output ready);
endinterface

// ===== src/lrpt_rsp_if.sv =====
interface lrpt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] insert_status;
    logic       found;

    modport source (output valid, insert_status, found, input ready);
    modport sink   (input valid, insert_status, found, output ready);
endinterface

// ===== src/lrpt_ram.sv =====
module lrpt_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lrpt_hash.sv =====
module lrpt_hash #(
    parameter int SLOTS = 64,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lrpt_pkg::t_key      i_key,
    output logic                o_done,
    output logic [IW-1:0]       o_home
);

    localparam int HW = lrpt_pkg::HASH_W;
    localparam int SW = $clog2(SLOTS + 1);
    localparam int DW = SW + HW - 1;
    localparam int CW = $clog2(lrpt_pkg::RED_CYC + 1);
    localparam logic [DW-1:0] DIV_INIT = DW'(SLOTS) << (HW - 1);

    logic [HW-1:0] r_s, r_t, r_x;
    logic [HW-1:0] n_s, n_t, n_x0, n_xr;
    logic [DW-1:0] r_div, n_div;
    logic [CW-1:0] r_cnt;
    logic          r_run, r_done;

    logic [9:0]    b_sum;
    logic [24:0]   prod;
    logic [8:0]    quo;
    logic [HW-1:0] quo10;
    logic [3:0]    rem;

    // 256^k mod 10 == 6 for k >= 1, so the tuple folds to b0 + 6*(b1+b2+b3)
    always_comb begin
        b_sum = 10'(i_key.tup[15:8]) + 10'(i_key.tup[23:16]) + 10'(i_key.tup[30:24]);
        n_s   = HW'({b_sum, 2'b00}) + HW'({b_sum, 1'b0}) + HW'(i_key.tup[7:0]);
        n_t   = HW'({i_key.tab, 3'b000}) + HW'({i_key.tab, 1'b0});
    end

    always_comb begin
        prod  = 25'(r_s) * 25'(lrpt_pkg::RECIP);
        quo   = prod[24:16];
        quo10 = HW'({quo, 3'b000}) + HW'({quo, 1'b0});
        rem   = 4'(r_s - quo10);
        n_x0  = r_t + HW'(rem);
    end

    // restoring reduction mod SLOTS, a few bits per cycle
    always_comb begin
        logic [HW-1:0] x;
        logic [DW-1:0] d;
        x = r_x;
        d = r_div;
        for (int j = 0; j < lrpt_pkg::RED_PER; j++) begin
            if (DW'(x) >= d) begin
                x = x - HW'(d);
            end
            d = d >> 1;
        end
        n_xr  = x;
        n_div = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(lrpt_pkg::RED_CYC)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s   <= n_s;
            r_t   <= n_t;
            r_div <= DIV_INIT;
        end else if (r_run) begin
            if (r_cnt == '0) begin
                r_x <= n_x0;
            end else begin
                r_x   <= n_xr;
                r_div <= n_div;
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_x[IW-1:0];

endmodule

// ===== src/lock_record_probe_table_unit.sv =====
// Lock record table of one transaction: open addressing with linear probing over SLOTS
// entries held in one single-port-write, registered-read RAM (valid bit stored with each
// entry). Insert and query first form the home slot in the hash unit, then read one slot
// per cycle from the RAM, probing 1 to SLOTS slots. Clear writes every slot once. After
// reset a clearing pass over every slot runs before the first request is taken. One
// request is in flight at a time; the next is accepted while the previous result still
// waits in the output register.
module lock_record_probe_table_unit #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrpt_req_if.sink    i_req,
    lrpt_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    lrpt_pkg::t_state  r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_cnt, n_cnt;
    lrpt_pkg::t_req    r_req;
    lrpt_pkg::t_key    r_key;
    logic              r_mode;
    logic [1:0]        r_status, n_status;
    logic              r_found, n_found;
    logic              r_ov;
    logic [1:0]        r_ost;
    logic              r_ofd;

    logic              w_acc, w_start, w_end, w_we, w_load;
    lrpt_pkg::t_entry  w_wdata, w_rdata;
    lrpt_pkg::t_key    w_key;
    logic              h_done;
    logic [IW-1:0]     h_home;
    logic              key_match, last_probe;
    logic [IW-1:0]     idx_next;

    assign i_req.ready = (r_state == lrpt_pkg::S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_start     = w_acc && (i_req.req_type == lrpt_pkg::REQ_INSERT ||
                                   i_req.req_type == lrpt_pkg::REQ_QUERY);
    assign w_key.tab   = i_req.table_num;
    assign w_key.tup   = i_req.tuple_num;

    lrpt_hash #(.SLOTS(SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_key   (w_key),
        .o_done  (h_done),
        .o_home  (h_home)
    );

    lrpt_ram #(.WIDTH($bits(lrpt_pkg::t_entry)), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_rdata)
    );

    assign key_match  = (w_rdata.tab == r_key.tab) && (w_rdata.tup == r_key.tup);
    assign last_probe = (r_cnt == LAST);
    assign idx_next   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign w_load     = (r_state == lrpt_pkg::S_DONE) && (!r_ov || o_rsp.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrpt_pkg::S_INIT: begin
                if (r_idx == LAST) n_state = lrpt_pkg::S_IDLE;
            end
            lrpt_pkg::S_IDLE: begin
                if (w_acc) begin
                    unique case (lrpt_pkg::t_req'(i_req.req_type))
                        lrpt_pkg::REQ_INSERT,
                        lrpt_pkg::REQ_QUERY: n_state = lrpt_pkg::S_HASH;
                        lrpt_pkg::REQ_CLEAR: n_state = lrpt_pkg::S_CLEAR;
                        default:             n_state = lrpt_pkg::S_DONE;
                    endcase
                end
            end
            lrpt_pkg::S_HASH: begin
                if (h_done) n_state = lrpt_pkg::S_CHECK;
            end
            lrpt_pkg::S_CHECK: begin
                if (w_end) n_state = lrpt_pkg::S_DONE;
            end
            lrpt_pkg::S_CLEAR: begin
                if (r_idx == LAST) n_state = lrpt_pkg::S_DONE;
            end
            lrpt_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) n_state = lrpt_pkg::S_IDLE;
            end
            default: n_state = lrpt_pkg::S_INIT;
        endcase
    end

    // datapath and memory control; read address always tracks n_idx so the entry at
    // r_idx is on the RAM output in S_CHECK
    always_comb begin
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_found  = r_found;
        w_we     = 1'b0;
        w_end    = 1'b0;
        w_wdata  = '0;
        unique case (r_state)
            lrpt_pkg::S_INIT, lrpt_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = idx_next;
            end
            lrpt_pkg::S_IDLE: begin
                n_idx = '0;
            end
            lrpt_pkg::S_HASH: begin
                n_cnt = '0;
                if (h_done) n_idx = h_home;
            end
            lrpt_pkg::S_CHECK: begin
                if (r_req == lrpt_pkg::REQ_INSERT) begin
                    if (!w_rdata.valid) begin
                        w_we          = 1'b1;
                        w_wdata.valid = 1'b1;
                        w_wdata.mode  = r_mode;
                        w_wdata.tup   = r_key.tup;
                        w_wdata.tab   = r_key.tab;
                        n_status      = lrpt_pkg::ST_INSERTED;
                        w_end         = 1'b1;
                    end else if (key_match) begin
                        n_status = lrpt_pkg::ST_HELD;
                        w_end    = 1'b1;
                    end else if (last_probe) begin
                        n_status = lrpt_pkg::ST_FULL;
                        w_end    = 1'b1;
                    end
                end else begin
                    if (!w_rdata.valid || last_probe) begin
                        w_end = 1'b1;
                    end
                    if (w_rdata.valid && key_match && w_rdata.mode == r_mode) begin
                        n_found = 1'b1;
                        w_end   = 1'b1;
                    end
                end
                if (!w_end) begin
                    n_idx = idx_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lrpt_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrpt_pkg::S_INIT;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req    <= lrpt_pkg::t_req'(i_req.req_type);
            r_key    <= w_key;
            r_mode   <= i_req.lock_mode;
            r_status <= lrpt_pkg::ST_INSERTED;
            r_found  <= 1'b0;
        end else begin
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (w_load) begin
            r_ost <= r_status;
            r_ofd <= r_found;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.insert_status = r_ost;
    assign o_rsp.found         = r_ofd;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrpt_pkg::S_IDLE) |-> !w_we)
        else $error("RAM write while idle");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != lrpt_pkg::S_IDLE))
        else $error("accepted transaction did not start work");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrpt_pkg::S_CHECK && r_req == lrpt_pkg::REQ_QUERY) |-> !w_we)
        else $error("query wrote the table");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.found && o_rsp.insert_status != lrpt_pkg::ST_INSERTED))
        else $error("result carries both insert status and query hit");

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int IW = $clog2(SLOTS);
    localparam int RAND_ITEMS = 1400;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 100;
    // request code that leaves the table as it is; the block still returns a result
    localparam logic [1:0] REQ_NOP = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tab;
        logic [30:0] tup;
        logic        mode;
        bit          drain;   // hold this transaction until all results are back
    } t_lock_req;

    typedef struct {
        logic [1:0] status;
        logic       found;
    } t_lock_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lrpt_req_if req_ch ();
    lrpt_rsp_if rsp_ch ();

    lock_record_probe_table_unit #(
        .SLOTS (SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the lock table
    bit          held_valid [SLOTS];
    logic [7:0]  held_tab   [SLOTS];
    logic [30:0] held_tup   [SLOTS];
    logic        held_mode  [SLOTS];

    t_lock_req    pending_reqs [$];
    t_lock_result expected_results [$];
    t_lock_req    cur_req;

    int errors = 0;
    int n_done = 0;
    int sent_cnt = 0;
    int gap_left = 0;
    int stall_left = 0;
    int stuck_cycles = 0;
    bit idle_allowed = 1'b0;

    function automatic t_lock_result apply_lock_request(t_lock_req r);
        t_lock_result  res;
        int unsigned   tab_u;
        int unsigned   tup_u;
        logic [IW-1:0] slot;
        int            n;
        bit            done;
        res.status = lrpt_pkg::ST_INSERTED;
        res.found  = 1'b0;
        tab_u = 32'(r.tab);
        tup_u = 32'(r.tup);
        slot  = IW'(((tab_u * 10) % SLOTS + tup_u % 10) % SLOTS);
        done  = 1'b0;
        case (r.kind)
            lrpt_pkg::REQ_INSERT: begin
                for (n = 0; n < SLOTS && !done; n++) begin
                    if (!held_valid[slot]) begin
                        held_valid[slot] = 1'b1;
                        held_tab[slot]   = r.tab;
                        held_tup[slot]   = r.tup;
                        held_mode[slot]  = r.mode;
                        done = 1'b1;
                    end else if (held_tab[slot] == r.tab && held_tup[slot] == r.tup) begin
                        // key already held: stored mode stays as it is
                        res.status = lrpt_pkg::ST_HELD;
                        done = 1'b1;
                    end else begin
                        slot = (slot == IW'(SLOTS - 1)) ? '0 : slot + 1'b1;
                    end
                end
                if (!done)
                    res.status = lrpt_pkg::ST_FULL;
            end
            lrpt_pkg::REQ_QUERY: begin
                for (n = 0; n < SLOTS && held_valid[slot] && !done; n++) begin
                    if (held_tab[slot] == r.tab && held_tup[slot] == r.tup &&
                        held_mode[slot] == r.mode) begin
                        res.found = 1'b1;
                        done = 1'b1;
                    end else begin
                        slot = (slot == IW'(SLOTS - 1)) ? '0 : slot + 1'b1;
                    end
                end
            end
            lrpt_pkg::REQ_CLEAR: begin
                foreach (held_valid[i])
                    held_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_req(input logic [1:0] kind, input logic [7:0] tab,
                            input logic [30:0] tup, input logic mode, input bit drain);
        pending_reqs.push_back('{kind, tab, tup, mode, drain});
    endtask

    function automatic logic [7:0] random_tab();
        return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [30:0] random_tup();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 9) == 0)
            w = 0;
        else if ($urandom_range(0, 4) == 0)
            w = $urandom_range(0, 30);
        return w[30:0];
    endfunction

    // request driver
    always @(posedge i_clk) begin : req_driver
        t_lock_result res;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            idle_allowed <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                res = apply_lock_request(cur_req);
                expected_results.push_back(res);
                sent_cnt++;
            end
            idle_allowed <= (pending_reqs.size() > 150) && (((sent_cnt / 150) % 3) != 2);
            if (req_ch.valid && !req_ch.ready) begin
                // transaction still waiting, hold it
            end else if (gap_left != 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (pending_reqs[0].drain && n_done != sent_cnt) begin
                req_ch.valid <= 1'b0;
            end else begin
                cur_req = pending_reqs.pop_front();
                req_ch.req_type  <= cur_req.kind;
                req_ch.table_num <= cur_req.tab;
                req_ch.tuple_num <= cur_req.tup;
                req_ch.lock_mode <= cur_req.mode;
                req_ch.valid     <= 1'b1;
                if (idle_allowed && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 15);
            end
        end
    end

    // response monitor and backpressure
    always @(posedge i_clk) begin : rsp_monitor
        t_lock_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response, expected none, got status %0d found %0d",
                             $time, rsp_ch.insert_status, rsp_ch.found);
                end else begin
                    want = expected_results.pop_front();
                    n_done <= n_done + 1;
                    if (rsp_ch.insert_status !== want.status) begin
                        errors++;
                        $display("%0t: insert_status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp_ch.insert_status);
                    end
                    if (rsp_ch.found !== want.found) begin
                        errors++;
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $time, want.found, rsp_ch.found);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic [7:0]  pool_tab [$];
        logic [30:0] pool_tup [$];
        logic [7:0]  base_tab;
        logic [30:0] base_tup;
        int          real_items;
        int          pool_n;
        int          ops;
        int          pick;
        int          dice;
        int          total;
        bit          fill;

        i_rst_n = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = lrpt_pkg::REQ_INSERT;
        req_ch.table_num = '0;
        req_ch.tuple_num = '0;
        req_ch.lock_mode = 1'b0;
        rsp_ch.ready     = 1'b0;

        // directed: extremes, collisions, wraparound, ignored codes, clear
        push_req(lrpt_pkg::REQ_QUERY,  8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd255, 31'h7FFF_FFFF, 1'b0, 1'b0);  // held, mode kept
        push_req(lrpt_pkg::REQ_QUERY,  8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_QUERY,  8'd255, 31'h7FFF_FFFF, 1'b0, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd0,   31'd0,         1'b0, 1'b0);  // zero ids
        push_req(lrpt_pkg::REQ_INSERT, 8'd0,   31'd10,        1'b1, 1'b0);  // same home slot
        push_req(lrpt_pkg::REQ_QUERY,  8'd0,   31'd10,        1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd6,   31'd3,         1'b0, 1'b0);  // last slot
        push_req(lrpt_pkg::REQ_INSERT, 8'd6,   31'd13,        1'b1, 1'b0);  // wraps around, lands in slot 2
        push_req(lrpt_pkg::REQ_QUERY,  8'd6,   31'd13,        1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_QUERY,  8'd6,   31'd23,        1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd1,   31'h2AAA_AAAA, 1'b0, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd254, 31'h5555_5555, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_QUERY,  8'd254, 31'h5555_5555, 1'b1, 1'b0);
        push_req(REQ_NOP,              8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(REQ_NOP,              8'd0,   31'd0,         1'b0, 1'b0);
        push_req(lrpt_pkg::REQ_QUERY,  8'd0,   31'd0,         1'b0, 1'b0);
        push_req(lrpt_pkg::REQ_CLEAR,  8'd0,   31'd0,         1'b0, 1'b1);
        push_req(lrpt_pkg::REQ_QUERY,  8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_INSERT, 8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);
        push_req(lrpt_pkg::REQ_CLEAR,  8'd255, 31'h7FFF_FFFF, 1'b1, 1'b0);

        // random episodes: clear, then lock traffic on a key set; some fill the table
        real_items = 0;
        while (real_items < RAND_ITEMS) begin
            fill   = ($urandom_range(0, 3) == 0);
            pool_n = fill ? $urandom_range(66, 90) : $urandom_range(2, 40);
            base_tab = 8'($urandom_range(0, 31));
            base_tup = 31'($urandom_range(0, 9));
            pool_tab.delete();
            pool_tup.delete();
            for (int k = 0; k < pool_n; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    // tables 32 apart and tuples 10 apart share a home slot
                    pool_tab.push_back(base_tab + 8'(32 * $urandom_range(0, 7)));
                    pool_tup.push_back(base_tup + 31'(10 * $urandom_range(0, 1000)));
                end else begin
                    pool_tab.push_back(random_tab());
                    pool_tup.push_back(random_tup());
                end
            end
            push_req(lrpt_pkg::REQ_CLEAR, random_tab(), random_tup(),
                     1'($urandom_range(0, 1)), 1'b1);
            real_items++;
            if (fill) begin
                for (int k = 0; k < pool_n; k++)
                    push_req(lrpt_pkg::REQ_INSERT, pool_tab[k], pool_tup[k],
                             1'($urandom_range(0, 1)), 1'b0);
                real_items += pool_n;
            end
            ops = $urandom_range(15, 80);
            for (int k = 0; k < ops; k++) begin
                pick = $urandom_range(0, pool_n - 1);
                dice = $urandom_range(0, 99);
                if (dice < 40)
                    push_req(lrpt_pkg::REQ_INSERT, pool_tab[pick], pool_tup[pick],
                             1'($urandom_range(0, 1)), 1'b0);
                else if (dice < 75)
                    push_req(lrpt_pkg::REQ_QUERY, pool_tab[pick], pool_tup[pick],
                             1'($urandom_range(0, 1)), 1'b0);
                else if (dice < 85)
                    push_req(lrpt_pkg::REQ_QUERY, random_tab(), random_tup(),
                             1'($urandom_range(0, 1)), 1'b0);
                else if (dice < 92)
                    push_req(lrpt_pkg::REQ_INSERT, random_tab(), random_tup(),
                             1'($urandom_range(0, 1)), 1'b0);
                else if (dice < 96)
                    push_req(REQ_NOP, random_tab(), random_tup(),
                             1'($urandom_range(0, 1)), 1'b0);
                else
                    push_req(lrpt_pkg::REQ_CLEAR, random_tab(), random_tup(),
                             1'($urandom_range(0, 1)), 1'b0);
                if (dice < 92 || dice >= 96)
                    real_items++;
            end
        end
        total = pending_reqs.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_done != total)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
